/* src/sorted_topn_insert_assert.svh */
// assertion macros for the sorted top-n table
// used by sorted_topn_insert, expects clk_i and rst_ni in scope
`ifndef SORTED_TOPN_INSERT_ASSERT_SVH
`define SORTED_TOPN_INSERT_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define STI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted_topn_insert: check failed");

// condition in one cycle implies a consequence in the next
`define STI_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sorted_topn_insert: check failed");

`else

`define STI_ASSERT(name, prop)
`define STI_ASSERT_NEXT(name, pre, post)

`endif

`endif

/* src/sti_pkg.sv */
// shared types and constants for the sorted top-n table
// no dependencies
package sti_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned ScoreW            = 32;
  localparam int unsigned DateW             = 63;
  localparam int unsigned NameWordW         = 64;
  localparam int unsigned NameWords         = 4;
  localparam int unsigned IndexW            = 6;
  localparam int unsigned RankW             = 7;

  // request codes
  typedef enum logic {
    ReqInsert = 1'b0,
    ReqRead   = 1'b1
  } req_e;

  // one table entry
  typedef struct packed {
    logic [ScoreW-1:0]                   score;
    logic [DateW-1:0]                    date;
    logic [NameWords-1:0][NameWordW-1:0] name;
  } entry_t;

  // per-cell update control
  typedef struct packed {
    logic take_new;   // load the incoming entry
    logic take_prev;  // load the entry of the upper neighbour
  } cell_ctrl_t;

endpackage

/* src/sti_cell.sv */
// one table cell: holds a single entry and its score compare
// depends on sti_pkg
module sti_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sti_pkg::cell_ctrl_t ctrl_i,
  input  sti_pkg::entry_t    new_i,
  input  sti_pkg::entry_t    prev_i,
  output sti_pkg::entry_t    entry_o,
  output logic               le_o
);
  import sti_pkg::*;

  entry_t entry_d, entry_q;

  // stored score not greater than the incoming one
  assign le_o = (entry_q.score <= new_i.score);

  // load new entry, shift from neighbour, or hold
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.take_new) begin
      entry_d = new_i;
    end else if (ctrl_i.take_prev) begin
      entry_d = prev_i;
    end
  end

  // cleared to an empty slot at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

/* src/sorted_topn_insert.sv */
// sorted top-n table built as a row of cells, one entry per cell
// each transaction is registered in the input stage, then its result in the output register
// throughput: one transaction per cycle unless the output stalls, set by one compare-and-shift pass over all cells
// reset: asynchronous, clears every cell to an empty slot (score zero) at once
// depends on sti_pkg, sti_cell and sorted_topn_insert_assert.svh
`include "sorted_topn_insert_assert.svh"

module sorted_topn_insert #(
  parameter int unsigned TableDepth = sti_pkg::TableDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [sti_pkg::IndexW-1:0]    entry_index_i,
  input  logic [sti_pkg::ScoreW-1:0]    entry_score_i,
  input  logic [sti_pkg::DateW-1:0]     entry_date_i,
  input  logic [sti_pkg::NameWordW-1:0] name_word0_i,
  input  logic [sti_pkg::NameWordW-1:0] name_word1_i,
  input  logic [sti_pkg::NameWordW-1:0] name_word2_i,
  input  logic [sti_pkg::NameWordW-1:0] name_word3_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sti_pkg::RankW-1:0]     placed_rank_o,
  output logic [sti_pkg::ScoreW-1:0]    read_score_o,
  output logic [sti_pkg::DateW-1:0]     read_date_o,
  output logic [sti_pkg::NameWordW-1:0] read_name0_o,
  output logic [sti_pkg::NameWordW-1:0] read_name1_o,
  output logic [sti_pkg::NameWordW-1:0] read_name2_o,
  output logic [sti_pkg::NameWordW-1:0] read_name3_o
);
  import sti_pkg::*;

  localparam int unsigned SelW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW  = $clog2(TableDepth + 1);

  // input stage
  logic       in_valid_q;
  logic       req_q;
  logic [IndexW-1:0] index_q;
  entry_t     new_q;
  logic       fire;

  assign fire       = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q         <= req_type_i;
      index_q       <= entry_index_i;
      new_q.score   <= entry_score_i;
      new_q.date    <= entry_date_i;
      new_q.name[0] <= name_word0_i;
      new_q.name[1] <= name_word1_i;
      new_q.name[2] <= name_word2_i;
      new_q.name[3] <= name_word3_i;
    end
  end

  // row of cells
  entry_t     cell_entry [TableDepth];
  logic       cell_le    [TableDepth];
  cell_ctrl_t cell_ctrl  [TableDepth];
  logic [TableDepth-1:0] boundary;
  logic [TableDepth-1:0] take_new_vec;
  logic       do_insert;

  assign do_insert = fire && (req_q == ReqInsert) && (new_q.score != '0);

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    entry_t prev_entry;
    logic   prev_le;

    if (i == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_le    = 1'b0;
    end else begin : g_rest
      assign prev_entry = cell_entry[i-1];
      assign prev_le    = cell_le[i-1];
    end

    // first cell whose score is not above the new one takes it, later cells shift
    assign boundary[i]            = cell_le[i] && !prev_le;
    assign cell_ctrl[i].take_new  = do_insert && boundary[i];
    assign cell_ctrl[i].take_prev = do_insert && prev_le;
    assign take_new_vec[i]        = cell_ctrl[i].take_new;

    sti_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[i]),
      .new_i   (new_q),
      .prev_i  (prev_entry),
      .entry_o (cell_entry[i]),
      .le_o    (cell_le[i])
    );
  end

  // rank of the insert position, depth if nothing placed
  logic [CntW-1:0]   rank_enc;
  logic [CntW-1:0]   rank;
  logic [CntW+RankW-1:0] rank_ext;

  always_comb begin
    rank_enc = '0;
    for (int i = 0; i < TableDepth; i++) begin
      rank_enc = rank_enc | (boundary[i] ? CntW'(i) : '0);
    end
  end

  assign rank     = ((new_q.score != '0) && (boundary != '0)) ? rank_enc : CntW'(TableDepth);
  assign rank_ext = {{RankW{1'b0}}, rank};

  // read selection
  logic [SelW+IndexW-1:0] index_ext;
  logic [SelW-1:0]        sel;
  logic                   in_range;
  entry_t                 rd_entry;

  assign index_ext = {{SelW{1'b0}}, index_q};
  assign sel       = index_ext[SelW-1:0];
  assign in_range  = ({26'b0, index_q} < 32'(TableDepth));
  assign rd_entry  = in_range ? cell_entry[sel] : '0;

  // output register
  logic              out_valid_q;
  logic [RankW-1:0]  rank_q;
  entry_t            rd_q;
  logic [CntW+RankW-1:0] depth_ext;

  assign depth_ext = {{RankW{1'b0}}, CntW'(TableDepth)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (req_q == ReqInsert) begin
        rank_q <= rank_ext[RankW-1:0];
        rd_q   <= '0;
      end else begin
        rank_q <= depth_ext[RankW-1:0];
        rd_q   <= rd_entry;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign placed_rank_o = rank_q;
  assign read_score_o  = rd_q.score;
  assign read_date_o   = rd_q.date;
  assign read_name0_o  = rd_q.name[0];
  assign read_name1_o  = rd_q.name[1];
  assign read_name2_o  = rd_q.name[2];
  assign read_name3_o  = rd_q.name[3];

  // table order check
  logic sorted_ok;

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 1; i < TableDepth; i++) begin
      sorted_ok = sorted_ok && (cell_entry[i-1].score >= cell_entry[i].score);
    end
  end

  `STI_ASSERT(a_table_sorted, sorted_ok)
  `STI_ASSERT(a_single_insert_cell, $onehot0(take_new_vec))
  `STI_ASSERT_NEXT(a_zero_score_keeps_head, fire && (req_q == ReqInsert) && (new_q.score == '0), cell_entry[0] == $past(cell_entry[0]))
  `STI_ASSERT_NEXT(a_read_keeps_head, fire && (req_q == ReqRead), $stable(cell_entry[0]))

endmodule
